// ===== rtl/sfdp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sfdp_pkg
// Types and constants for the starfield depth update and projection block.
// ----------------------------------------------------------------------------
package sfdp_pkg;

  localparam int IN_BYTES  = 9;   // 65 payload bits
  localparam int OUT_BYTES = 7;   // 50 payload bits
  localparam int PQ_BITS   = 12;  // projection quotient magnitude bits
  localparam int IQ_BITS   = 8;   // intensity quotient bits
  localparam logic signed [34:0] ONE_Q24 = 35'sd16777216;

  typedef enum logic [2:0] {
    REG_DEPTH_SPEED   = 3'd0,
    REG_FOCAL_LENGTH  = 3'd1,
    REG_CENTER_X      = 3'd2,
    REG_CENTER_Y      = 3'd3,
    REG_VIEW_WIDTH    = 3'd4,
    REG_VIEW_HEIGHT   = 3'd5,
    REG_BRIGHTNESS    = 3'd6,
    REG_UNUSED        = 3'd7
  } reg_idx_t;

  // after speed * time product
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [16:0]        zin;
    logic [31:0]        prod;
  } s1_t;

  // after depth wrap
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [16:0]        z;
  } s2_t;

  // after projection and z^2 products
  typedef struct packed {
    logic signed [27:0] fx;
    logic signed [27:0] fy;
    logic [27:0]        cxz;
    logic [27:0]        cyz;
    logic [33:0]        zz;
    logic [16:0]        z;
  } s3_t;

  // one division step of both projections and the intensity
  typedef struct packed {
    logic [28:0]        rem_u;
    logic [PQ_BITS-1:0] q_u;
    logic               neg_u;
    logic               ovf_u;
    logic [28:0]        rem_v;
    logic [PQ_BITS-1:0] q_v;
    logic               neg_v;
    logic               ovf_v;
    logic [39:0]        rem_i;
    logic [IQ_BITS-1:0] q_i;
    logic               ovf_i;
    logic [33:0]        zz;
    logic [16:0]        z;
  } step_t;

  typedef struct packed {
    logic [7:0]         intensity;
    logic               visible;
    logic signed [11:0] pixel_v;
    logic signed [11:0] pixel_u;
    logic [16:0]        new_depth;
  } res_t;

endpackage
`default_nettype wire

// ===== rtl/starfield_depth_update_and_project_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// starfield_depth_update_and_project_top
// Moves one star towards the viewer and projects it to a screen pixel.
// ----------------------------------------------------------------------------
// Fully pipelined: one star per clock while the result side does not stall.
// Three stages form the depth update (speed * time product, then the single
// wrap, clamped into [0,1]) and the projection and z^2 products; a fourth
// forms the signed numerators, their magnitudes and the quotient overflow
// tests; twelve further stages each retire one quotient bit of the restoring
// dividers for u and v, the first eight of them also one bit of the intensity
// divider; the last stage saturates, applies the visibility test and is the
// output register. A stall on the result side freezes every
// stage at once, so nothing is lost or repeated, and s_axis_tready stays high
// whenever the output register is empty or being taken. Configuration
// writes are always accepted (cfg_ready is tied high) and should be issued
// only while no star is in flight. Register index 7 is ignored.
// ----------------------------------------------------------------------------
module starfield_depth_update_and_project_top
  import sfdp_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // star_x[15:0], star_y[31:16], star_z[48:32], elapsed_ms[64:49], zero pad
  input  wire logic [IN_BYTES*8-1:0]  s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // new_depth[16:0], pixel_u[28:17], pixel_v[40:29], visible[41],
  // intensity[49:42], zero pad
  output logic [OUT_BYTES*8-1:0]      m_axis_tdata,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [2:0]             cfg_index,
  input  wire logic [15:0]            cfg_data
);

  localparam int NSTAGE = 3 + PQ_BITS + 2;  // s1..s3, step regs 0..12, out

  // configuration
  logic [15:0] depth_speed;
  logic [10:0] focal_length;
  logic [10:0] center_x;
  logic [10:0] center_y;
  logic [10:0] view_width;
  logic [10:0] view_height;
  logic [15:0] brightness;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_speed   <= 16'd8389;
      focal_length  <= 11'd240;
      center_x      <= 11'd320;
      center_y      <= 11'd240;
      view_width    <= 11'd640;
      view_height   <= 11'd480;
      brightness    <= 16'd13107;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_DEPTH_SPEED:   depth_speed   <= cfg_data;
        REG_FOCAL_LENGTH:  focal_length  <= cfg_data[10:0];
        REG_CENTER_X:      center_x      <= cfg_data[10:0];
        REG_CENTER_Y:      center_y      <= cfg_data[10:0];
        REG_VIEW_WIDTH:    view_width    <= cfg_data[10:0];
        REG_VIEW_HEIGHT:   view_height   <= cfg_data[10:0];
        REG_BRIGHTNESS:    brightness    <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline control: whole pipe moves unless the result is held
  logic [NSTAGE-1:0] vld;
  logic              en;

  assign en            = !vld[NSTAGE-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[NSTAGE-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSTAGE-2:0], s_axis_tvalid};
    end
  end

  // stage 1: speed * elapsed time
  s1_t s1, s1_next;
  always_comb begin
    s1_next.x    = s_axis_tdata[15:0];
    s1_next.y    = s_axis_tdata[31:16];
    s1_next.zin  = s_axis_tdata[48:32];
    s1_next.prod = depth_speed * s_axis_tdata[64:49];
  end

  // stage 2: move and single wrap, in units of 2^-24
  s2_t s2, s2_next;
  logic signed [34:0] zt;
  always_comb begin
    zt = $signed({10'b0, s1.zin, 8'b0}) - $signed({3'b0, s1.prod});
    if (zt <= 0)       zt = zt + ONE_Q24;
    if (zt > ONE_Q24)  zt = zt - ONE_Q24;
    if (zt < 0)        zt = '0;
    if (zt > ONE_Q24)  zt = ONE_Q24;
    s2_next.x = s1.x;
    s2_next.y = s1.y;
    s2_next.z = zt[24:8];
  end

  // stage 3: projection products and z^2
  s3_t s3, s3_next;
  always_comb begin
    s3_next.fx  = $signed({1'b0, focal_length}) * s2.x;
    s3_next.fy  = $signed({1'b0, focal_length}) * s2.y;
    s3_next.cxz = center_x * s2.z;
    s3_next.cyz = center_y * s2.z;
    s3_next.zz  = s2.z * s2.z;
    s3_next.z   = s2.z;
  end

  // stage 4: numerators, magnitudes, overflow tests
  step_t st [0:PQ_BITS];
  step_t st0_next;
  logic signed [29:0] num_u, num_v;
  logic [23:0]        bnum;
  always_comb begin
    num_u = $signed({s3.fx[27], s3.fx, 1'b0}) + $signed({2'b0, s3.cxz});
    num_v = $signed({s3.fy[27], s3.fy, 1'b0}) + $signed({2'b0, s3.cyz});
    bnum  = {brightness, 8'b0} - {8'b0, brightness};  // 255 * brightness
    st0_next.neg_u = num_u[29];
    st0_next.rem_u = num_u[29] ? 29'(-num_u) : num_u[28:0];
    st0_next.ovf_u = {1'b0, st0_next.rem_u} >= ({13'b0, s3.z} << PQ_BITS);
    st0_next.q_u   = '0;
    st0_next.neg_v = num_v[29];
    st0_next.rem_v = num_v[29] ? 29'(-num_v) : num_v[28:0];
    st0_next.ovf_v = {1'b0, st0_next.rem_v} >= ({13'b0, s3.z} << PQ_BITS);
    st0_next.q_v   = '0;
    st0_next.rem_i = {bnum, 16'b0};
    st0_next.ovf_i = {2'b0, bnum, 8'b0} >= s3.zz;
    st0_next.q_i   = '0;
    st0_next.zz    = s3.zz;
    st0_next.z     = s3.z;
  end

  // restoring divider steps: one quotient bit per stage
  step_t st_next [1:PQ_BITS];
  always_comb begin
    for (int i = 0; i < PQ_BITS; i++) begin
      logic [29:0] dz;
      logic [40:0] dzz;
      st_next[i+1] = st[i];
      dz  = {13'b0, st[i].z} << (PQ_BITS - 1 - i);
      dzz = '0;
      if ({1'b0, st[i].rem_u} >= dz) begin
        st_next[i+1].rem_u = 29'({1'b0, st[i].rem_u} - dz);
        st_next[i+1].q_u[PQ_BITS-1-i] = 1'b1;
      end
      if ({1'b0, st[i].rem_v} >= dz) begin
        st_next[i+1].rem_v = 29'({1'b0, st[i].rem_v} - dz);
        st_next[i+1].q_v[PQ_BITS-1-i] = 1'b1;
      end
      if (i < IQ_BITS) begin
        dzz = {7'b0, st[i].zz} << (IQ_BITS - 1 - i);
        if ({1'b0, st[i].rem_i} >= dzz) begin
          st_next[i+1].rem_i = 40'({1'b0, st[i].rem_i} - dzz);
          st_next[i+1].q_i[IQ_BITS-1-i] = 1'b1;
        end
      end
    end
  end

  // final stage: sign, saturation, visibility, intensity
  res_t res, res_next;
  logic signed [12:0] su, sv;
  always_comb begin
    if (st[PQ_BITS].neg_u)
      su = (st[PQ_BITS].ovf_u || st[PQ_BITS].q_u > 12'd2048) ? -13'sd2048
           : -$signed({1'b0, st[PQ_BITS].q_u});
    else
      su = (st[PQ_BITS].ovf_u || st[PQ_BITS].q_u > 12'd2047) ? 13'sd2047
           : $signed({1'b0, st[PQ_BITS].q_u});
    if (st[PQ_BITS].neg_v)
      sv = (st[PQ_BITS].ovf_v || st[PQ_BITS].q_v > 12'd2048) ? -13'sd2048
           : -$signed({1'b0, st[PQ_BITS].q_v});
    else
      sv = (st[PQ_BITS].ovf_v || st[PQ_BITS].q_v > 12'd2047) ? 13'sd2047
           : $signed({1'b0, st[PQ_BITS].q_v});
    res_next.new_depth = st[PQ_BITS].z;
    if (st[PQ_BITS].z == '0) begin
      res_next.pixel_u = '0;
      res_next.pixel_v = '0;
      res_next.visible = 1'b0;
    end else begin
      res_next.pixel_u = su[11:0];
      res_next.pixel_v = sv[11:0];
      res_next.visible = !su[12] && !sv[12] &&
                         (su[10:0] < view_width) && (sv[10:0] < view_height);
    end
    if (!res_next.visible)         res_next.intensity = '0;
    else if (st[PQ_BITS].ovf_i)    res_next.intensity = 8'd255;
    else                           res_next.intensity = st[PQ_BITS].q_i;
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (en) begin
      s1    <= s1_next;
      s2    <= s2_next;
      s3    <= s3_next;
      st[0] <= st0_next;
      for (int i = 1; i <= PQ_BITS; i++) st[i] <= st_next[i];
      res   <= res_next;
    end
  end

  assign m_axis_tdata = {(OUT_BYTES*8 - 50)'(0), res};

  // checks
  a_enter: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> vld[0])
    else $error("accepted star not captured");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("pipeline moved during stall");
  a_dark: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !res.visible |-> res.intensity == '0)
    else $error("invisible star has intensity");
  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && res.new_depth == '0 |->
      !res.visible && res.pixel_u == '0 && res.pixel_v == '0)
    else $error("zero depth star not blanked");
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> res.new_depth <= 17'd65536)
    else $error("depth above one");

endmodule
`default_nettype wire

// ===== bench/starfield_depth_update_and_project_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// starfield_depth_update_and_project_top_tb
// Self-checking bench for the star depth update and projection pipeline.
// ----------------------------------------------------------------------------
// A directed table covers the extremes and special cases, then random stars
// run through several register settings. Each output transaction is checked
// field by field against an in-bench projection predictor. Both the star
// source and the pixel sink idle at random.
// ----------------------------------------------------------------------------
module starfield_depth_update_and_project_top_tb;
  import sfdp_pkg::*;

  localparam int PIPE_CYCLES = 17;

  // star fields
  typedef struct {
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic [16:0]        sz;
    logic [15:0]        dt;
  } star_t;

  // directed row: star, plus an optional typed-in expectation
  typedef struct {
    star_t star;
    bit    fixed;
    res_t  res;
  } row_t;

  logic clk;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [IN_BYTES*8-1:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [OUT_BYTES*8-1:0] m_axis_tdata;
  logic cfg_valid;
  logic cfg_ready;
  logic [2:0] cfg_index;
  logic [15:0] cfg_data;

  // shadow copy of the register file
  logic [15:0] speed_r;
  logic [10:0] focal_r, cx_r, cy_r, width_r, height_r;
  logic [15:0] bright_r;

  res_t pixel_q[$];
  int   errors;
  bit   sink_hold;   // long hold-off requested by the source process

  starfield_depth_update_and_project_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Truncating division toward zero, clipped to the 12-bit pixel range.
  function automatic longint project_axis(longint pos, longint focal, longint centre,
                                          longint z);
    longint num, q;
    num = 2 * focal * pos + centre * z;
    q = num / z;
    if (q > 2047) q = 2047;
    if (q < -2048) q = -2048;
    return q;
  endfunction

  function automatic res_t project_star(star_t s);
    res_t   r;
    longint z24, z, u, v, q;
    r = '0;
    z24 = longint'(s.sz) * 256 - longint'(speed_r) * longint'(s.dt);
    if (z24 <= 0) z24 += 64'sd16777216;          // one wrap back to the far plane
    if (z24 > 64'sd16777216) z24 -= 64'sd16777216;
    if (z24 < 0) z24 = 0;                         // wrap not enough: clamp
    if (z24 > 64'sd16777216) z24 = 64'sd16777216;
    z = z24 >>> 8;
    r.new_depth = z[16:0];
    if (z != 0) begin
      u = project_axis(s.sx, focal_r, cx_r, z);
      v = project_axis(s.sy, focal_r, cy_r, z);
      r.pixel_u = u[11:0];
      r.pixel_v = v[11:0];
      if (u >= 0 && u < width_r && v >= 0 && v < height_r) begin
        q = (255 * longint'(bright_r) * 65536) / (z * z);
        r.visible = 1'b1;
        r.intensity = (q > 255) ? 8'd255 : q[7:0];
      end
    end
    return r;
  endfunction

  task automatic write_reg(reg_idx_t idx, logic [15:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_DEPTH_SPEED:   speed_r  = val;
      REG_FOCAL_LENGTH:  focal_r  = val[10:0];
      REG_CENTER_X:      cx_r     = val[10:0];
      REG_CENTER_Y:      cy_r     = val[10:0];
      REG_VIEW_WIDTH:    width_r  = val[10:0];
      REG_VIEW_HEIGHT:   height_r = val[10:0];
      REG_BRIGHTNESS:    bright_r = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Let the pipeline drain fully before touching registers.
  task automatic drain_pipe();
    s_axis_tvalid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (PIPE_CYCLES + 4) @(posedge clk);
  endtask

  // Offer one star; the expectation is queued at the accepting edge.
  // Valid stays high after acceptance so the next star can follow at once.
  task automatic send_star(star_t s, bit fixed, res_t fres, bit gaps);
    if (gaps && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(5, 30)
                                          : $urandom_range(1, 3)) @(posedge clk);
    end
    s_axis_tdata  <= {7'd0, s.dt, s.sz, s.sy, s.sx};
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pixel_q.push_back(fixed ? fres : project_star(s));
  endtask

  function automatic star_t rand_star(bit near);
    star_t s;
    s.sx = 16'($urandom);
    s.sy = 16'($urandom);
    // mostly near the centre so projections land on screen
    if (near) begin
      s.sx = 16'(int'($urandom_range(0, 2047)) - 1024);
      s.sy = 16'(int'($urandom_range(0, 2047)) - 1024);
    end
    case ($urandom_range(0, 5))
      0:       s.sz = 17'd65536;
      1:       s.sz = 17'($urandom_range(0, 255));
      2:       s.sz = 17'($urandom_range(65537, 131071));
      default: s.sz = 17'($urandom_range(0, 65536));
    endcase
    case ($urandom_range(0, 4))
      0:       s.dt = 16'($urandom);
      1:       s.dt = 16'hffff;
      default: s.dt = 16'($urandom_range(0, 40));
    endcase
    return s;
  endfunction

  // Pixel sink: random stalls, plus a long hold-off on request.
  initial begin
    m_axis_tready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (sink_hold) begin
        m_axis_tready <= 1'b0;
        repeat (60) @(posedge clk);
        sink_hold = 1'b0;
      end
      if ($urandom_range(0, 19) == 0)
        m_axis_tready <= 1'b0;
      else if ($urandom_range(0, 3) == 0)
        m_axis_tready <= ($urandom_range(0, 1) == 1);
      else
        m_axis_tready <= 1'b1;
    end
  end

  // Output checker
  always @(posedge clk) begin
    res_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[49:0];
      if (pixel_q.size() == 0) begin
        $error("unexpected output transaction %h", m_axis_tdata);
        errors++;
      end else begin
        want = pixel_q.pop_front();
        if (got.new_depth !== want.new_depth) begin
          $error("new_depth exp %0d got %0d", want.new_depth, got.new_depth); errors++;
        end
        if (got.pixel_u !== want.pixel_u) begin
          $error("pixel_u exp %0d got %0d", want.pixel_u, got.pixel_u); errors++;
        end
        if (got.pixel_v !== want.pixel_v) begin
          $error("pixel_v exp %0d got %0d", want.pixel_v, got.pixel_v); errors++;
        end
        if (got.visible !== want.visible) begin
          $error("visible exp %0d got %0d", want.visible, got.visible); errors++;
        end
        if (got.intensity !== want.intensity) begin
          $error("intensity exp %0d got %0d", want.intensity, got.intensity); errors++;
        end
      end
    end
  end

  // Stimulus
  initial begin
    row_t  rows[$];
    row_t  rw;
    star_t s;
    res_t  none;
    int    n;
    errors = 0;
    sink_hold = 0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_DEPTH_SPEED;
    cfg_data = '0;
    speed_r = 16'd8389; focal_r = 11'd240; cx_r = 11'd320; cy_r = 11'd240;
    width_r = 11'd640; height_r = 11'd480; bright_r = 16'd13107;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    none = '0;
    // Directed rows with reset registers. Fixed rows: zero depth gives all zeros.
    rw.fixed = 1; rw.res = none;
    // near plane, long frame: one wrap cannot recover, depth clamps to zero
    rw.star = '{16'sd0, 16'sd0, 17'd0, 16'hffff}; rows.push_back(rw);
    // depth 1.0, no movement: centre pixel, intensity 255*13107/65536 truncates to 50
    rw.res = '{intensity: 8'd50, visible: 1'b1, pixel_v: 12'sd240, pixel_u: 12'sd320,
               new_depth: 17'd65536};
    rw.star = '{16'sd0, 16'sd0, 17'd65536, 16'd0}; rows.push_back(rw);
    rw.fixed = 0;
    rw.star = '{-16'sd32768, 16'sd32767, 17'd65536, 16'd0}; rows.push_back(rw);
    rw.star = '{16'sd32767, -16'sd32768, 17'd1, 16'd0}; rows.push_back(rw);  // saturation
    rw.star = '{16'sd100, 16'sd100, 17'd1, 16'd1}; rows.push_back(rw);       // wrap once
    rw.star = '{16'sd0, 16'sd0, 17'd0, 16'hffff}; rows.push_back(rw);         // wrap not enough
    rw.star = '{16'sd0, 16'sd0, 17'd131071, 16'd0}; rows.push_back(rw);       // above 1.0
    rw.star = '{16'sd0, 16'sd0, 17'd131071, 16'hffff}; rows.push_back(rw);
    rw.star = '{16'sd500, -16'sd500, 17'd300, 16'd0}; rows.push_back(rw);     // near, off screen
    rw.star = '{16'sd0, 16'sd0, 17'd33, 16'd1}; rows.push_back(rw);           // depth truncates to zero
    rw.star = '{16'sd1000, 16'sd1000, 17'd20000, 16'd3}; rows.push_back(rw);
    foreach (rows[i]) send_star(rows[i].star, rows[i].fixed, rows[i].res, 0);

    // Long sink hold-off while the source keeps offering.
    sink_hold = 1'b1;
    repeat (40) send_star(rand_star(1), 0, none, 0);
    // Source pauses until every pixel has come back.
    drain_pipe();

    // Register settings, extremes among them; index 7 must be ignored.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_DEPTH_SPEED, 16'd0);     write_reg(REG_FOCAL_LENGTH, 16'd1);
          write_reg(REG_CENTER_X, 16'd0);        write_reg(REG_CENTER_Y, 16'd0);
          write_reg(REG_VIEW_WIDTH, 16'd1);      write_reg(REG_VIEW_HEIGHT, 16'd1);
          write_reg(REG_BRIGHTNESS, 16'd0);
        end
        1: begin
          write_reg(REG_DEPTH_SPEED, 16'hffff);  write_reg(REG_FOCAL_LENGTH, 16'd2047);
          write_reg(REG_CENTER_X, 16'd2047);     write_reg(REG_CENTER_Y, 16'd2047);
          write_reg(REG_VIEW_WIDTH, 16'd2047);   write_reg(REG_VIEW_HEIGHT, 16'd2047);
          write_reg(REG_BRIGHTNESS, 16'hffff);
        end
        2: begin
          // out of stated range: zero focal and zero screen
          write_reg(REG_FOCAL_LENGTH, 16'd0);    write_reg(REG_VIEW_WIDTH, 16'd0);
          write_reg(REG_UNUSED, 16'hffff);
        end
        3: begin
          write_reg(REG_VIEW_WIDTH, 16'd0);      write_reg(REG_VIEW_HEIGHT, 16'd0);
          write_reg(REG_FOCAL_LENGTH, 16'hf800);  // upper bits dropped
        end
        default: begin
          write_reg(REG_DEPTH_SPEED, 16'($urandom));
          write_reg(REG_FOCAL_LENGTH, 16'($urandom_range(1, 2047)));
          write_reg(REG_CENTER_X, 16'($urandom_range(0, 2047)));
          write_reg(REG_CENTER_Y, 16'($urandom_range(0, 2047)));
          write_reg(REG_VIEW_WIDTH, 16'($urandom_range(1, 2047)));
          write_reg(REG_VIEW_HEIGHT, 16'($urandom_range(1, 2047)));
          write_reg(REG_BRIGHTNESS, 16'($urandom));
        end
      endcase
      n = (phase < 4) ? 150 : 600;
      repeat (n) begin
        s = rand_star($urandom_range(0, 3) != 0);
        send_star(s, 0, none, 1);
      end
      drain_pipe();
    end

    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== starfield_depth_update_and_project_top.f =====
rtl/sfdp_pkg.sv
rtl/starfield_depth_update_and_project_top.sv
bench/starfield_depth_update_and_project_top_tb.sv
